### rtl/core/qte_pkg.sv
`default_nettype none

package qte_pkg;

    // output angle width, 2^(ANGLE_BITS-1) stands for pi
    localparam int ANGLE_BITS = 16;

    // datapath widths
    localparam int SUM_W      = 64;
    localparam int VEC_W      = 44;
    localparam int ANG_W      = 34;
    localparam int YAW_W      = 32;
    localparam int RAD_W      = 61;
    localparam int ROOT_W     = 64;
    localparam int SHIFT_W    = 5;
    localparam int NORM_BITS  = 40;
    localparam int SQRT_STEPS = 32;
    localparam int ATAN_DEPTH = 32;
    localparam int ATAN_IW    = 5;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // quarter turn in units of pi/2^31
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sd1073741824;

    // atan(2^-i) in units of pi/2^31
    localparam logic [31:0] ATAN_STEP [ATAN_DEPTH] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } qte_in_t;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] pitch_angle;
        logic signed [ANGLE_BITS-1:0] yaw_angle;
        logic signed [ANGLE_BITS-1:0] roll_angle;
    } qte_out_t;

    // one cordic lane: vector, angle accumulator, zero vector flag
    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [ANG_W-1:0] z;
        logic                    zero;
    } qte_vec_t;

    // queue entry: prepared pitch and roll lanes, yaw argument and radicand
    typedef struct packed {
        qte_vec_t                pitch;
        qte_vec_t                roll;
        logic signed [YAW_W-1:0] yaw_t;
        logic [RAD_W-1:0]        rad;
    } qte_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qte_fifo_stat_t;

    // one vectoring iteration
    function automatic qte_vec_t cordic_step(qte_vec_t v, logic [ATAN_IW-1:0] i);
        qte_vec_t                r;
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;
        logic signed [ANG_W-1:0] a;
        dx = v.x >>> i;
        dy = v.y >>> i;
        a  = ANG_W'(ATAN_STEP[i]);
        r  = v;
        if (v.y > 0)
        begin
            r.x = v.x + dy;
            r.y = v.y - dx;
            r.z = v.z + a;
        end
        else
        begin
            r.x = v.x - dy;
            r.y = v.y + dx;
            r.z = v.z - a;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/quaternion_to_euler_angles_unit.sv
`default_nettype none

// Converts a unit quaternion (Q1.14) into ZYX Euler angles as binary angles
// (32768 = pi): pitch and roll from atan2, yaw from asin of the clamped
// argument. Fully pipelined: one quaternion is taken every cycle unless a full
// queue holds the front, and one result leaves every cycle while out_ready is
// high; either side may stall independently. A six-stage front forms the
// products and sums, clamps and rescales the yaw argument and normalizes the
// atan2 vectors; it feeds a four-entry queue. The back runs a 32-stage square
// root chain for the asin cosine term, then CORDIC_STEPS stages of three
// parallel CORDIC lanes and an output register.
module quaternion_to_euler_angles_unit #(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int CORDIC_STEPS   = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire qte_pkg::qte_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output qte_pkg::qte_out_t      out_data
);

    logic                    push;
    logic                    pop;
    qte_pkg::qte_item_t      wr_item;
    qte_pkg::qte_item_t      rd_item;
    qte_pkg::qte_fifo_stat_t fifo_stat;

    // operand preparation
    qte_front #(
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (push),
        .item      (wr_item),
        .fifo_stat (fifo_stat)
    );

    // decoupling queue
    qte_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wr_item),
        .pop   (pop),
        .rdata (rd_item),
        .stat  (fifo_stat)
    );

    // square root and cordic
    qte_back #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .item      (rd_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // front stalls only on a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !in_ready |-> fifo_stat.full)
        else $error("front stalled with room in the queue");

    // no write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !fifo_stat.full)
        else $error("queue overflow");

    // no read from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !fifo_stat.empty)
        else $error("queue underflow");

endmodule

`default_nettype wire

### rtl/core/qte_fifo.sv
`default_nettype none

module qte_fifo (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire qte_pkg::qte_item_t        wdata,
    input  wire logic                      pop,
    output qte_pkg::qte_item_t             rdata,
    output qte_pkg::qte_fifo_stat_t        stat
);

    localparam int AW = qte_pkg::FIFO_AW;
    localparam int CW = qte_pkg::FIFO_AW + 1;

    qte_pkg::qte_item_t mem_reg [qte_pkg::FIFO_DEPTH];
    logic [AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      count_reg, count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

    assign rdata      = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CW'(qte_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

### rtl/core/qte_front.sv
`default_nettype none

module qte_front #(
    parameter int QUAT_FRAC_BITS = 14
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire qte_pkg::qte_in_t          in_data,
    output logic                           push,
    output qte_pkg::qte_item_t             item,
    input  wire qte_pkg::qte_fifo_stat_t   fifo_stat
);

    localparam int SW  = qte_pkg::SUM_W;
    localparam int VW  = qte_pkg::VEC_W;
    localparam int YW  = qte_pkg::YAW_W;
    localparam int RW  = qte_pkg::RAD_W;
    localparam int HW  = qte_pkg::SHIFT_W;
    localparam int K   = 2 * QUAT_FRAC_BITS;
    localparam int SHR = (K >= 30) ? K - 30 : 0;
    localparam int SHL = (K >= 30) ? 0 : 30 - K;
    localparam logic signed [SW-1:0] ONE     = 64'sd1 <<< K;
    localparam logic signed [SW-1:0] NEG_ONE = -ONE;
    localparam logic [RW-1:0]        RAD_ONE = 61'd1 << 60;

    typedef struct packed {
        logic signed [SW-1:0] t0;
        logic signed [SW-1:0] t1;
        logic signed [SW-1:0] t3;
        logic signed [SW-1:0] t4;
    } sums_t;

    logic               en;
    logic [6:1]         v_reg;

    qte_pkg::qte_in_t   q_reg;
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg, wz_reg, xy_reg, zz_reg;
    sums_t              s3_reg, s4_reg, s5_reg;
    sums_t              s3_next;
    logic signed [SW-1:0] t2c_reg, t2c_next;
    logic signed [YW-1:0] t2s_next, s4_yaw_reg, s5_yaw_reg;
    logic [SW-1:0]      sq_reg;
    logic [SW-1:0]      mag_p_reg, mag_r_reg;
    logic               zp4_reg, zr4_reg, zp5_reg, zr5_reg;
    logic [HW-1:0]      sh_p_reg, sh_r_reg;
    logic [RW-1:0]      rad_reg;
    qte_pkg::qte_item_t item_reg;

    function automatic logic [SW-1:0] mag(logic signed [SW-1:0] v);
        return v[SW-1] ? SW'(-v) : SW'(v);
    endfunction

    // shift needed to bring the larger magnitude below 2^40
    function automatic logic [HW-1:0] lead_shift(logic [SW-1:0] m);
        logic [HW-1:0] s;
        s = '0;
        for (int b = qte_pkg::NORM_BITS; b < SW; b++)
        begin
            if (m[b])
                s = HW'(b - qte_pkg::NORM_BITS + 1);
        end
        return s;
    endfunction

    // scale down and turn a left half plane vector into the right half plane
    function automatic qte_pkg::qte_vec_t prep_vec(logic signed [SW-1:0] yv,
                                                   logic signed [SW-1:0] xv,
                                                   logic [HW-1:0] s, logic zero);
        qte_pkg::qte_vec_t    r;
        logic signed [VW-1:0] xs;
        logic signed [VW-1:0] ys;
        xs     = VW'(xv >>> s);
        ys     = VW'(yv >>> s);
        r.zero = zero;
        r.x    = xs;
        r.y    = ys;
        r.z    = '0;
        if (xs < 0)
        begin
            if (ys >= 0)
            begin
                r.x = ys;
                r.y = -xs;
                r.z = qte_pkg::QUARTER_TURN;
            end
            else
            begin
                r.x = -ys;
                r.y = xs;
                r.z = -qte_pkg::QUARTER_TURN;
            end
        end
        return r;
    endfunction

    // the whole front holds while its last request waits on a full queue
    assign en       = !v_reg[6] || !fifo_stat.full;
    assign in_ready = en;
    assign push     = v_reg[6] && !fifo_stat.full;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[5:1], in_valid};
    end

    // sums, differences and the yaw clamp
    always_comb
    begin
        s3_next.t0 = (SW'(wx_reg) + SW'(yz_reg)) <<< 1;
        s3_next.t1 = ONE - ((SW'(xx_reg) + SW'(yy_reg)) <<< 1);
        s3_next.t3 = (SW'(wz_reg) + SW'(xy_reg)) <<< 1;
        s3_next.t4 = ONE - ((SW'(yy_reg) + SW'(zz_reg)) <<< 1);
        t2c_next   = (SW'(wy_reg) - SW'(zx_reg)) <<< 1;
        if (t2c_next > ONE)
            t2c_next = ONE;
        if (t2c_next < NEG_ONE)
            t2c_next = NEG_ONE;
    end

    // yaw argument moved to 30 fraction bits
    always_comb
    begin
        if (K >= 30)
            t2s_next = YW'(t2c_reg >>> SHR);
        else
            t2s_next = YW'(t2c_reg <<< SHL);
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg      <= in_data;

            wx_reg     <= q_reg.quat_w * q_reg.quat_x;
            yz_reg     <= q_reg.quat_y * q_reg.quat_z;
            xx_reg     <= q_reg.quat_x * q_reg.quat_x;
            yy_reg     <= q_reg.quat_y * q_reg.quat_y;
            wy_reg     <= q_reg.quat_w * q_reg.quat_y;
            zx_reg     <= q_reg.quat_z * q_reg.quat_x;
            wz_reg     <= q_reg.quat_w * q_reg.quat_z;
            xy_reg     <= q_reg.quat_x * q_reg.quat_y;
            zz_reg     <= q_reg.quat_z * q_reg.quat_z;

            s3_reg     <= s3_next;
            t2c_reg    <= t2c_next;

            s4_reg     <= s3_reg;
            s4_yaw_reg <= t2s_next;
            sq_reg     <= SW'(t2s_next * t2s_next);
            mag_p_reg  <= mag(s3_reg.t0) | mag(s3_reg.t1);
            mag_r_reg  <= mag(s3_reg.t3) | mag(s3_reg.t4);
            zp4_reg    <= (s3_reg.t0 == '0) && (s3_reg.t1 == '0);
            zr4_reg    <= (s3_reg.t3 == '0) && (s3_reg.t4 == '0);

            s5_reg     <= s4_reg;
            s5_yaw_reg <= s4_yaw_reg;
            sh_p_reg   <= lead_shift(mag_p_reg);
            sh_r_reg   <= lead_shift(mag_r_reg);
            rad_reg    <= RAD_ONE - RW'(sq_reg);
            zp5_reg    <= zp4_reg;
            zr5_reg    <= zr4_reg;

            item_reg.pitch <= prep_vec(s5_reg.t0, s5_reg.t1, sh_p_reg, zp5_reg);
            item_reg.roll  <= prep_vec(s5_reg.t3, s5_reg.t4, sh_r_reg, zr5_reg);
            item_reg.yaw_t <= s5_yaw_reg;
            item_reg.rad   <= rad_reg;
        end
    end

endmodule

`default_nettype wire

### rtl/core/qte_back.sv
`default_nettype none

module qte_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire qte_pkg::qte_fifo_stat_t   fifo_stat,
    output logic                           pop,
    input  wire qte_pkg::qte_item_t        item,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output qte_pkg::qte_out_t              out_data
);

    localparam int SQ  = qte_pkg::SQRT_STEPS;
    localparam int N   = CORDIC_STEPS;
    localparam int VW  = qte_pkg::VEC_W;
    localparam int AW  = qte_pkg::ANG_W;
    localparam int RT  = qte_pkg::ROOT_W;
    localparam int AB  = qte_pkg::ANGLE_BITS;
    localparam int IW  = qte_pkg::ATAN_IW;
    localparam int SH  = 32 - AB;
    localparam logic signed [AW:0] RND = (SH > 0) ? (35'sd1 <<< (SH - 1)) : 35'sd0;

    typedef struct packed {
        qte_pkg::qte_vec_t           pitch;
        qte_pkg::qte_vec_t           roll;
        logic signed [qte_pkg::YAW_W-1:0] yaw_t;
        logic [RT-1:0]               rem;
        logic [RT-1:0]               root;
    } sq_t;

    typedef struct packed {
        qte_pkg::qte_vec_t pitch;
        qte_pkg::qte_vec_t yaw;
        qte_pkg::qte_vec_t roll;
    } cd_t;

    logic              en;
    logic [SQ:0]       sq_v_reg;
    logic [N:0]        cd_v_reg;
    logic              out_valid_reg;
    sq_t               sq_reg [SQ+1];
    sq_t               sq_next [SQ+1];
    cd_t               cd_reg [N+1];
    cd_t               cd_first;
    qte_pkg::qte_out_t out_reg;

    function automatic logic signed [AB-1:0] to_angle(qte_pkg::qte_vec_t v);
        logic signed [AW:0] zs;
        zs = (AW + 1)'(v.z) + RND;
        return v.zero ? '0 : zs[SH +: AB];
    endfunction

    // whole back pipeline moves when the output register can take a result
    assign en        = !out_valid_reg || out_ready;
    assign pop       = en && !fifo_stat.empty;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg      <= '0;
            cd_v_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg      <= {sq_v_reg[SQ-1:0], pop};
            cd_v_reg      <= {cd_v_reg[N-1:0], sq_v_reg[SQ]};
            out_valid_reg <= cd_v_reg[N];
        end
    end

    // queue entry into the square root chain
    always_comb
    begin
        sq_next[0].pitch = item.pitch;
        sq_next[0].roll  = item.roll;
        sq_next[0].yaw_t = item.yaw_t;
        sq_next[0].rem   = RT'(item.rad);
        sq_next[0].root  = '0;
    end

    // digit by digit square root, one result bit per stage
    for (genvar g = 0; g < SQ; g++)
    begin : g_sqrt
        localparam logic [RT-1:0] BIT = 64'd1 << (62 - 2 * g);
        logic [RT-1:0] trial;
        always_comb
        begin
            trial          = sq_reg[g].root + BIT;
            sq_next[g + 1] = sq_reg[g];
            if (sq_reg[g].rem >= trial)
            begin
                sq_next[g + 1].rem  = sq_reg[g].rem - trial;
                sq_next[g + 1].root = (sq_reg[g].root >> 1) + BIT;
            end
            else
            begin
                sq_next[g + 1].root = sq_reg[g].root >> 1;
            end
        end
    end

    for (genvar g = 0; g <= SQ; g++)
    begin : g_sqrt_reg
        always_ff @(posedge clk)
        begin
            if (en)
                sq_reg[g] <= sq_next[g];
        end
    end

    // yaw lane: asin(t) as the angle of (sqrt(1-t*t), t)
    always_comb
    begin
        cd_first.pitch    = sq_reg[SQ].pitch;
        cd_first.roll     = sq_reg[SQ].roll;
        cd_first.yaw.x    = VW'(sq_reg[SQ].root);
        cd_first.yaw.y    = VW'(sq_reg[SQ].yaw_t);
        cd_first.yaw.z    = '0;
        cd_first.yaw.zero = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            cd_reg[0] <= cd_first;
    end

    // cordic stages, three lanes side by side
    for (genvar g = 0; g < N; g++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cd_reg[g + 1].pitch <= qte_pkg::cordic_step(cd_reg[g].pitch, IW'(g));
                cd_reg[g + 1].yaw   <= qte_pkg::cordic_step(cd_reg[g].yaw, IW'(g));
                cd_reg[g + 1].roll  <= qte_pkg::cordic_step(cd_reg[g].roll, IW'(g));
            end
        end
    end

    // round to the output angle width
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.pitch_angle <= to_angle(cd_reg[N].pitch);
            out_reg.yaw_angle   <= to_angle(cd_reg[N].yaw);
            out_reg.roll_angle  <= to_angle(cd_reg[N].roll);
        end
    end

endmodule

`default_nettype wire

### bench/qte_checker.sv
`default_nettype none

module qte_checker
    import qte_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = 14,
    parameter int CORDIC_STEPS   = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    input  wire logic     in_ready,
    input  wire qte_in_t  in_data,
    input  wire logic     out_valid,
    input  wire logic     out_ready,
    input  wire qte_out_t out_data,
    output int            fail_count,
    output int            angles_pending,
    output int            angles_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    qte_out_t expected_angles[$];

    // atan(2^-i) in units of pi/2^31
    localparam longint ATAN_TABLE [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    // exact integer square root, bit by bit
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // vectoring angle of (vx, vy), units of pi/2^31
    function automatic longint vector_angle(longint vy, longint vx);
        longint acc;
        longint tmp;
        longint dx;
        longint dy;
        longint unsigned m;
        int s;
        acc = 0;
        s = 0;
        if (vx == 0 && vy == 0)
            return 0;
        m = longint'(vx < 0 ? -vx : vx) | longint'(vy < 0 ? -vy : vy);
        while (s < 63 && (m >> s) >= (64'd1 << 40))
            s++;
        vx = vx >>> s;
        vy = vy >>> s;
        // left half plane: quarter turn first
        if (vx < 0)
        begin
            tmp = vx;
            if (vy >= 0)
            begin
                vx = vy;
                vy = -tmp;
                acc = 1073741824;
            end
            else
            begin
                vx = -vy;
                vy = tmp;
                acc = -1073741824;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 63; i++)
        begin
            dx = vx >>> i;
            dy = vy >>> i;
            if (vy > 0)
            begin
                vx += dy;
                vy -= dx;
                acc += (i < 32) ? ATAN_TABLE[i] : 0;
            end
            else
            begin
                vx -= dy;
                vy += dx;
                acc -= (i < 32) ? ATAN_TABLE[i] : 0;
            end
        end
        return acc;
    endfunction

    // round half up to the angle width and wrap
    function automatic logic [ANGLE_BITS-1:0] binary_angle(longint acc);
        int sh;
        sh = 32 - ANGLE_BITS;
        if (sh > 0)
            acc = (acc + (longint'(1) << (sh - 1))) >>> sh;
        return acc[ANGLE_BITS-1:0];
    endfunction

    function automatic qte_out_t euler_of(qte_in_t q);
        qte_out_t r;
        longint w, x, y, z, one, ysq, sp, cp, sy, sr, cr, cy;
        int k;
        w = q.quat_w;
        x = q.quat_x;
        y = q.quat_y;
        z = q.quat_z;
        k = 2 * QUAT_FRAC_BITS;
        one = longint'(1) << k;
        ysq = y * y;
        sp = 2 * (w * x + y * z);
        cp = one - 2 * (x * x + ysq);
        sy = 2 * (w * y - z * x);
        if (sy > one)
            sy = one;
        if (sy < -one)
            sy = -one;
        if (k >= 30)
            sy = sy >>> (k - 30);
        else
            sy = sy * (longint'(1) << (30 - k));
        cy = longint'(int_sqrt((64'd1 << 60) - longint'(sy * sy)));
        sr = 2 * (w * z + x * y);
        cr = one - 2 * (ysq + z * z);
        r.pitch_angle = binary_angle(vector_angle(sp, cp));
        r.yaw_angle   = binary_angle(vector_angle(sy, cy));
        r.roll_angle  = binary_angle(vector_angle(sr, cr));
        return r;
    endfunction

    // predict on each accepted request, compare on each accepted result
    always @(posedge clk)
    begin
        qte_out_t e;
        if (!rst_n)
        begin
            fail_count = 0;
            angles_checked = 0;
            angles_pending = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_angles.push_back(euler_of(in_data));
            if (out_valid && out_ready)
            begin
                angles_checked++;
                if (expected_angles.size() == 0)
                begin
                    $error("result with nothing expected: %h", out_data);
                    fail_count++;
                end
                else
                begin
                    e = expected_angles.pop_front();
                    if (e.pitch_angle !== out_data.pitch_angle)
                    begin
                        $error("pitch_angle expected %0d got %0d",
                               e.pitch_angle, out_data.pitch_angle);
                        fail_count++;
                    end
                    if (e.yaw_angle !== out_data.yaw_angle)
                    begin
                        $error("yaw_angle expected %0d got %0d",
                               e.yaw_angle, out_data.yaw_angle);
                        fail_count++;
                    end
                    if (e.roll_angle !== out_data.roll_angle)
                    begin
                        $error("roll_angle expected %0d got %0d",
                               e.roll_angle, out_data.roll_angle);
                        fail_count++;
                    end
                end
            end
            angles_pending = expected_angles.size();
        end
    end

endmodule

`default_nettype wire

### bench/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import qte_pkg::*;

    localparam int  LATENCY     = 16 + 41 + 20;
    localparam longint CYCLE_CAP = 400000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    qte_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    qte_out_t out_data;
    int       fail_count;
    int       angles_pending;
    int       angles_checked;
    int       send_idle_pct;
    int       recv_stall_pct;
    bit       long_hold;
    longint   cycle_count;

    quaternion_to_euler_angles_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    qte_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .angles_pending(angles_pending),
        .angles_checked(angles_checked)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // timeout watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result-side backpressure, with an optional long hold
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 0;
                repeat (300) @(posedge clk);
                long_hold = 0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    // roughly unit quaternion with random direction
    function automatic qte_in_t unit_quat();
        qte_in_t q;
        real a, b, c, d, n;
        a = $signed($urandom_range(2000)) - 1000;
        b = $signed($urandom_range(2000)) - 1000;
        c = $signed($urandom_range(2000)) - 1000;
        d = $signed($urandom_range(2000)) - 1000;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
        begin
            a = 1.0;
            n = 1.0;
        end
        q.quat_w = 16'($rtoi(16384.0 * a / n));
        q.quat_x = 16'($rtoi(16384.0 * b / n));
        q.quat_y = 16'($rtoi(16384.0 * c / n));
        q.quat_z = 16'($rtoi(16384.0 * d / n));
        return q;
    endfunction

    // offer one request and hold it until taken
    task automatic send_quat(qte_in_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data <= q;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (angles_pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    initial
    begin
        qte_in_t q;
        logic signed [15:0] ext [5];
        ext = '{16'sd16384, -16'sd16384, 16'sd0, 16'sh7fff, 16'sh8000};
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        long_hold = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: identity, axis turns, zero vector, gimbal lock, extremes
        send_quat('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
        send_quat('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
        send_quat('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
        send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
        send_quat('{16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
        send_quat('{16'sd11585, 16'sd0, -16'sd11585, 16'sd0});
        send_quat('{16'sd11585, 16'sd11585, 16'sd0, 16'sd0});
        send_quat('{16'sd11585, -16'sd11585, 16'sd0, 16'sd0});
        send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        send_quat('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
        send_quat('{16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192});
        send_quat('{16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384});
        for (int i = 0; i < 12; i++)
            send_quat('{ext[$urandom_range(4)], ext[$urandom_range(4)],
                        ext[$urandom_range(4)], ext[$urandom_range(4)]});
        drain();

        // random phases across idle and stall mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 12 : 74) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 12 : 74) : 0;
            if (ph == 0)
                long_hold = 1;
            for (int n = 0; n < 250; n++)
            begin
                if ($urandom_range(9) < 8)
                    q = unit_quat();
                else
                    q = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
                send_quat(q);
            end
            drain();
        end

        $display("covered %0d quaternions under four flow-control mixes,",
                 angles_checked);
        $display("including axis turns, gimbal lock, zero and out-of-range inputs");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
